// ===== hw/rtl/kfr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_pkg
// Shared types and constants of the keyed frame receiver.
// ----------------------------------------------------------------------------
package kfr_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 5;
    localparam int unsigned LEFT_W          = 3;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [7:0] HDR_B0 = 8'h4D;
    localparam logic [7:0] HDR_B1 = 8'h4A;
    localparam logic [7:0] HDR_B2 = 8'h58;
    localparam logic [7:0] CMD_1  = 8'h01;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_BAD_CMD = 2'd1;
    localparam logic [1:0] ERR_BAD_LEN = 2'd2;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_H1   = 3'd1,
        PH_H2   = 3'd2,
        PH_CMD  = 3'd3,
        PH_LEN  = 3'd4,
        PH_KEY  = 3'd5,
        PH_DATA = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        OP_KEY     = 3'd0,
        OP_DATA    = 3'd1,
        OP_ERR_CMD = 3'd2,
        OP_ERR_LEN = 3'd3,
        OP_ZERO    = 3'd4
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic       last;
    } t_req;

endpackage
`default_nettype wire

// ===== hw/rtl/kfr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_front
// Header hunt and frame phase machine; turns bytes into back-end requests.
// ----------------------------------------------------------------------------
module kfr_front #(
    parameter int unsigned MAX_PAYLOAD = kfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_rx_byte,
    output kfr_pkg::t_req      o_req,
    output logic               o_push
);
    import kfr_pkg::*;

    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

    t_phase             r_phase, n_phase;
    logic [LEFT_W-1:0]  r_left, n_left;
    logic [LEFT_W-1:0]  left_dec;
    logic               last;
    logic [7:0]         hunt_restart;

    assign left_dec = (r_left != '0) ? r_left - 1'b1 : r_left;
    assign last     = (left_dec == '0);
    assign hunt_restart = i_rx_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        if (i_accept) begin
            unique case (r_phase)
                PH_H1: begin
                    if (i_rx_byte == HDR_B1) n_phase = PH_H2;
                    else n_phase = (hunt_restart == HDR_B0) ? PH_H1 : PH_HUNT;
                end
                PH_H2: begin
                    if (i_rx_byte == HDR_B2) n_phase = PH_CMD;
                    else n_phase = (hunt_restart == HDR_B0) ? PH_H1 : PH_HUNT;
                end
                PH_CMD: begin
                    n_phase = (i_rx_byte == CMD_1) ? PH_LEN : PH_HUNT;
                end
                PH_LEN: begin
                    if (i_rx_byte > MAX_LEN || i_rx_byte == 8'd0) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_left  = i_rx_byte[LEFT_W-1:0];
                        n_phase = PH_KEY;
                    end
                end
                PH_KEY, PH_DATA: begin
                    n_left  = left_dec;
                    n_phase = last ? PH_HUNT : PH_DATA;
                end
                default: begin
                    n_phase = (hunt_restart == HDR_B0) ? PH_H1 : PH_HUNT;
                end
            endcase
        end
    end

    // request generation
    always_comb begin
        o_push     = 1'b0;
        o_req.op   = OP_ZERO;
        o_req.data = i_rx_byte;
        o_req.last = last;
        if (i_accept) begin
            unique case (r_phase)
                PH_CMD: begin
                    if (i_rx_byte != CMD_1) begin
                        o_push   = 1'b1;
                        o_req.op = OP_ERR_CMD;
                    end
                end
                PH_LEN: begin
                    if (i_rx_byte > MAX_LEN) begin
                        o_push   = 1'b1;
                        o_req.op = OP_ERR_LEN;
                    end else if (i_rx_byte == 8'd0) begin
                        o_push   = 1'b1;
                        o_req.op = OP_ZERO;
                    end
                end
                PH_KEY: begin
                    o_push   = 1'b1;
                    o_req.op = OP_KEY;
                end
                PH_DATA: begin
                    o_push   = 1'b1;
                    o_req.op = OP_DATA;
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kfr_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module kfr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  kfr_pkg::t_req       i_req,
    input  wire logic           i_pop,
    output kfr_pkg::t_req       o_req,
    output logic                o_avail,
    output logic                o_full
);
    import kfr_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_req               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_avail = (r_count != '0);
    assign o_req   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            if (do_pop)  r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/kfr_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kfr_back
// Executes requests: holds the key, descrambles, drives the output register.
// ----------------------------------------------------------------------------
module kfr_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_avail,
    input  kfr_pkg::t_req      i_req,
    output logic               o_pop,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [7:0]         o_out_byte,
    output logic               o_shift_valid,
    output logic               o_latch,
    output logic [1:0]         o_error_code
);
    import kfr_pkg::*;

    logic [7:0] r_key;
    logic [7:0] n_byte;
    logic       n_shift, n_latch;
    logic [1:0] n_err;

    assign o_pop = i_avail && (!o_valid || !i_stall);

    always_comb begin
        n_byte  = 8'd0;
        n_shift = 1'b0;
        n_latch = 1'b0;
        n_err   = ERR_NONE;
        unique case (i_req.op)
            OP_KEY: begin
                n_byte  = i_req.data;
                n_shift = 1'b1;
                n_latch = i_req.last;
            end
            OP_DATA: begin
                n_byte  = i_req.data - r_key;
                n_shift = 1'b1;
                n_latch = i_req.last;
            end
            OP_ERR_CMD: n_err = ERR_BAD_CMD;
            OP_ERR_LEN: n_err = ERR_BAD_LEN;
            OP_ZERO:    n_latch = 1'b1;
            default:    n_err = ERR_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_key   <= 8'd0;
        end else begin
            if (o_pop) begin
                o_valid <= 1'b1;
                if (i_req.op == OP_KEY) r_key <= i_req.data;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_out_byte    <= n_byte;
            o_shift_valid <= n_shift;
            o_latch       <= n_latch;
            o_error_code  <= n_err;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/keyed_frame_receiver_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_frame_receiver_unit
// Byte-stream frame receiver feeding a shift chain.
//
// Input channel: i_valid / o_stall with i_rx_byte, one request per byte.
// Output channel: o_valid / i_stall with o_out_byte, o_shift_valid, o_latch
// and o_error_code. Only bytes that end a frame in error, a zero-length
// frame, the key and payload bytes produce an output request; header,
// command and length bytes are absorbed.
// Throughput: one byte per cycle while o_stall is low. A result is
// registered on its way to the output: the front phase machine writes
// a two-entry queue, the back end reads it into the output register.
// While the receiver stalls, the queue absorbs up to two results; o_stall
// rises once it is full, and bytes are taken only while it is
// not full.
// Reset clears the phase machine, the queue and the key; hunting starts
// with the first byte after reset.
// ----------------------------------------------------------------------------
module keyed_frame_receiver_unit #(
    parameter int unsigned MAX_PAYLOAD = kfr_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire logic [7:0]    i_rx_byte,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_shift_valid,
    output logic               o_latch,
    output logic [1:0]         o_error_code
);
    import kfr_pkg::*;

    t_req   front_req, head_req;
    logic   push, pop, avail, full, accept;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    kfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .o_req     (front_req),
        .o_push    (push)
    );

    kfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .i_pop   (pop),
        .o_req   (head_req),
        .o_avail (avail),
        .o_full  (full)
    );

    kfr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (avail),
        .i_req         (head_req),
        .o_pop         (pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_byte    (o_out_byte),
        .o_shift_valid (o_shift_valid),
        .o_latch       (o_latch),
        .o_error_code  (o_error_code)
    );

endmodule
`default_nettype wire
